// File: design/psf_pkg.sv
// Shared types, status codes and the CRC-32/MPEG-2 byte update for the PSI section framer.
package psf_pkg;

    localparam int MAX_RES   = 8;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);

    localparam logic [11:0] LEN_MIN  = 12'd9;
    localparam logic [11:0] LEN_MAX  = 12'd1021;
    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic       REQ_HEADER  = 1'b0;
    localparam logic       REQ_PAYLOAD = 1'b1;

    localparam logic [7:0] TID_PAT = 8'd0;
    localparam logic [7:0] TID_PMT = 8'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LEN    = 3'd1;
    localparam logic [2:0] ST_BAD_NUM    = 3'd2;
    localparam logic [2:0] ST_BAD_TABLE  = 3'd3;
    localparam logic [2:0] ST_MISMATCH   = 3'd4;
    localparam logic [2:0] ST_UNEXPECTED = 3'd5;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  table_ident;
        logic [15:0] table_ext;
        logic [4:0]  version;
        logic [7:0]  sect_num;
        logic [7:0]  last_sect_num;
        logic [11:0] sect_len;
        logic [7:0]  payload_byte;
        logic        payload_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
        logic [2:0] status;
    } t_out_item;

    typedef struct packed {
        logic [RES_CNT_W-1:0]        count;
        t_out_item [MAX_RES-1:0]     items;
    } t_load;

    function automatic t_out_item mk_item(logic [7:0] b, logic last, logic [2:0] st);
        t_out_item it;
        it.out_byte = b;
        it.out_last = last;
        it.status   = st;
        return it;
    endfunction

    // Eight bit steps of the MSB-first CRC register.
    function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: design/psf_chan_if.sv
// Valid/ready stream channel carrying one payload item per request.
interface psf_chan_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: design/psf_res_buf.sv
// Result buffer: loads up to eight items at once, shifts one out per cycle while ready.
module psf_res_buf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  psf_pkg::t_load i_load_data,
    output logic           o_can_load,
    psf_chan_if.source     o_out
);

    psf_pkg::t_out_item [psf_pkg::MAX_RES-1:0] r_items;
    logic [psf_pkg::RES_CNT_W-1:0]             r_rem;

    logic fire_out;

    assign fire_out    = o_out.valid && o_out.ready;
    assign o_out.valid = (r_rem != '0);
    assign o_out.data  = r_items[0];
    // accept a new load while the final item leaves
    assign o_can_load  = (r_rem == '0) ||
                         ((r_rem == psf_pkg::RES_CNT_W'(1)) && o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_load_data.count;
        end else if (fire_out) begin
            r_rem <= r_rem - psf_pkg::RES_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_items <= i_load_data.items;
        end else if (fire_out) begin
            for (int i = 0; i < psf_pkg::MAX_RES - 1; i++) begin
                r_items[i] <= r_items[i+1];
            end
        end
    end

endmodule

// File: design/psf_section_framer_crc32_core.sv
// Block top: takes section header and payload byte requests and emits a framed PSI section
// with trailing CRC-32/MPEG-2. While the output is ready, a payload byte request is taken
// every cycle and gives its byte in the next cycle, and the result buffer delivers one byte
// per cycle. A header request yields eight bytes and a final payload byte five, and the
// next request is taken in the cycle the last of those bytes leaves. Header bytes after
// the first are folded into the CRC by a one-byte-per-cycle stepper within the drain.
module psi_section_framer_crc32_core #(
    parameter int MAX_SECTION_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    psf_chan_if.sink   i_in,
    psf_chan_if.source o_out
);

    localparam int MAX_EXP = (MAX_SECTION_BYTES - 12 < 1012) ? MAX_SECTION_BYTES - 12 : 1012;
    localparam int CNT_W   = $clog2(MAX_EXP + 2);
    localparam logic [12:0] MAX_BYTES = 13'(MAX_SECTION_BYTES);

    logic [31:0]      r_crc, n_crc;
    logic [CNT_W-1:0] r_seen, n_seen;
    logic [CNT_W-1:0] r_exp, n_exp;
    logic             r_in_sect, n_in_sect;
    logic             r_hbusy, n_hbusy;
    logic [2:0]       r_hstep;
    logic [7:0]       r_hdr [8];

    psf_pkg::t_in_item in_d;
    psf_pkg::t_load    n_load;
    logic              can_load;
    logic              fire_in;
    logic              hdr_ok;
    logic [7:0]        hdr [8];
    logic [31:0]       crc_p;
    logic [CNT_W:0]    seen_inc;
    logic              len_bad;

    assign in_d       = i_in.data;
    assign i_in.ready = can_load;
    assign fire_in    = i_in.valid && can_load;

    assign hdr[0] = in_d.table_ident;
    assign hdr[1] = {4'h8, in_d.sect_len[11:8]};
    assign hdr[2] = in_d.sect_len[7:0];
    assign hdr[3] = in_d.table_ext[15:8];
    assign hdr[4] = in_d.table_ext[7:0];
    assign hdr[5] = {2'b00, in_d.version, 1'b1};
    assign hdr[6] = in_d.sect_num;
    assign hdr[7] = in_d.last_sect_num;

    assign len_bad  = (in_d.sect_len < psf_pkg::LEN_MIN) || (in_d.sect_len > psf_pkg::LEN_MAX) ||
                      (({1'b0, in_d.sect_len} + 13'd3) > MAX_BYTES);
    assign seen_inc = {1'b0, r_seen} + (CNT_W + 1)'(1);
    assign crc_p    = psf_pkg::crc_byte(r_crc, in_d.payload_byte);

    always_comb begin
        n_crc     = r_crc;
        n_seen    = r_seen;
        n_exp     = r_exp;
        n_in_sect = r_in_sect;
        n_hbusy   = 1'b0;
        hdr_ok    = 1'b0;
        n_load    = '0;
        n_load.count = psf_pkg::RES_CNT_W'(1);
        if (in_d.req_type == psf_pkg::REQ_HEADER) begin
            n_in_sect = 1'b0;
            n_seen    = '0;
            n_exp     = '0;
            n_crc     = psf_pkg::CRC_INIT;
            if (len_bad) begin
                n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_BAD_LEN);
            end else if (in_d.sect_num > in_d.last_sect_num) begin
                n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_BAD_NUM);
            end else if ((in_d.table_ident != psf_pkg::TID_PAT) &&
                         (in_d.table_ident != psf_pkg::TID_PMT)) begin
                n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_BAD_TABLE);
            end else begin
                hdr_ok       = 1'b1;
                n_hbusy      = 1'b1;
                n_in_sect    = 1'b1;
                n_exp        = CNT_W'(in_d.sect_len - psf_pkg::LEN_MIN);
                // fold the first header byte now, the stepper takes the rest
                n_crc        = psf_pkg::crc_byte(psf_pkg::CRC_INIT, hdr[0]);
                n_load.count = psf_pkg::RES_CNT_W'(8);
                for (int i = 0; i < 8; i++) begin
                    n_load.items[i] = psf_pkg::mk_item(hdr[i], (i == 7), psf_pkg::ST_OK);
                end
            end
        end else if (!r_in_sect) begin
            n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_UNEXPECTED);
        end else if (r_exp == '0) begin
            n_in_sect = 1'b0;
            n_seen    = '0;
            n_exp     = '0;
            n_crc     = psf_pkg::CRC_INIT;
            if (in_d.payload_last) begin
                n_load.count    = psf_pkg::RES_CNT_W'(4);
                n_load.items[0] = psf_pkg::mk_item(r_crc[31:24], 1'b0, psf_pkg::ST_OK);
                n_load.items[1] = psf_pkg::mk_item(r_crc[23:16], 1'b0, psf_pkg::ST_OK);
                n_load.items[2] = psf_pkg::mk_item(r_crc[15:8], 1'b0, psf_pkg::ST_OK);
                n_load.items[3] = psf_pkg::mk_item(r_crc[7:0], 1'b1, psf_pkg::ST_OK);
            end else begin
                n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_MISMATCH);
            end
        end else if ((seen_inc > {1'b0, r_exp}) ||
                     (in_d.payload_last && (seen_inc != {1'b0, r_exp}))) begin
            n_in_sect = 1'b0;
            n_seen    = '0;
            n_exp     = '0;
            n_crc     = psf_pkg::CRC_INIT;
            n_load.items[0] = psf_pkg::mk_item(8'd0, 1'b1, psf_pkg::ST_MISMATCH);
        end else if (!in_d.payload_last) begin
            n_seen = seen_inc[CNT_W-1:0];
            n_crc  = crc_p;
            n_load.items[0] = psf_pkg::mk_item(in_d.payload_byte, 1'b1, psf_pkg::ST_OK);
        end else begin
            n_in_sect = 1'b0;
            n_seen    = '0;
            n_exp     = '0;
            n_crc     = psf_pkg::CRC_INIT;
            n_load.count    = psf_pkg::RES_CNT_W'(5);
            n_load.items[0] = psf_pkg::mk_item(in_d.payload_byte, 1'b0, psf_pkg::ST_OK);
            n_load.items[1] = psf_pkg::mk_item(crc_p[31:24], 1'b0, psf_pkg::ST_OK);
            n_load.items[2] = psf_pkg::mk_item(crc_p[23:16], 1'b0, psf_pkg::ST_OK);
            n_load.items[3] = psf_pkg::mk_item(crc_p[15:8], 1'b0, psf_pkg::ST_OK);
            n_load.items[4] = psf_pkg::mk_item(crc_p[7:0], 1'b1, psf_pkg::ST_OK);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= psf_pkg::CRC_INIT;
            r_seen    <= '0;
            r_exp     <= '0;
            r_in_sect <= 1'b0;
            r_hbusy   <= 1'b0;
            r_hstep   <= 3'd0;
        end else if (fire_in) begin
            r_crc     <= n_crc;
            r_seen    <= n_seen;
            r_exp     <= n_exp;
            r_in_sect <= n_in_sect;
            r_hbusy   <= n_hbusy;
            r_hstep   <= 3'd1;
        end else if (r_hbusy) begin
            // advance the header CRC one byte per cycle
            r_crc   <= psf_pkg::crc_byte(r_crc, r_hdr[r_hstep]);
            r_hstep <= r_hstep + 3'd1;
            if (r_hstep == 3'd7) begin
                r_hbusy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire_in && hdr_ok) begin
            for (int i = 0; i < 8; i++) begin
                r_hdr[i] <= hdr[i];
            end
        end
    end

    psf_res_buf u_res_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (fire_in),
        .i_load_data (n_load),
        .o_can_load  (can_load),
        .o_out       (o_out)
    );

endmodule
